// ===== rtl/core/trwp_pkg.sv =====
package trwp_pkg;

  localparam int ROW_W           = 12;
  localparam int ROW_MAX         = (1 << ROW_W) - 1;
  localparam int CNT_W           = 7;
  localparam int WKR_W           = 6;
  localparam int WGT_W           = ROW_W + 1;
  localparam int TOT_W           = 24;
  localparam int DEF_MAX_ROW     = 4095;
  localparam int DEF_MAX_WORKERS = 64;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 32;

  typedef struct packed {
    logic accept;
    logic init;
    logic div_start;
    logic step;
    logic flush;
    logic ld;
    logic next;
  } trwp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_end;
    logic opens;
    logic is_last;
  } trwp_sts_t;

endpackage

// ===== rtl/core/trwp_ram.sv =====
module trwp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/trwp_div.sv =====
module trwp_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    fits     = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/trwp_dp.sv =====
module trwp_dp #(
  parameter int MAX_ROW     = trwp_pkg::DEF_MAX_ROW,
  parameter int MAX_WORKERS = trwp_pkg::DEF_MAX_WORKERS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  trwp_pkg::trwp_cmd_t        cmd,
  output trwp_pkg::trwp_sts_t        sts,
  input  logic                       in_op,
  input  logic [trwp_pkg::ROW_W-1:0] in_row_limit,
  input  logic [trwp_pkg::CNT_W-1:0] in_worker_count,
  output logic [trwp_pkg::WKR_W-1:0] out_worker_index,
  output logic [trwp_pkg::ROW_W-1:0] out_first_row,
  output logic [trwp_pkg::ROW_W-1:0] out_final_row,
  output logic                       out_active,
  output logic                       out_last
);

  import trwp_pkg::*;

  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'((MAX_ROW > ROW_MAX) ? ROW_MAX : MAX_ROW);
  localparam logic [CNT_W-1:0] WKR_CAP = CNT_W'(MAX_WORKERS);

  logic             shape_r;
  logic [ROW_W-1:0] n_r;
  logic [CNT_W-1:0] t_r;
  logic [TOT_W-1:0] total_r, quota_r, load_r, done_sum_r, num_r;
  logic [CNT_W-1:0] den_r;
  logic [WGT_W-1:0] m_r;
  logic [WKR_W-1:0] cur_r, k_r;
  logic [ROW_W-1:0] lo_r, hi_r;

  logic [ROW_W-1:0] n_sat;
  logic [CNT_W-1:0] t_sat;
  logic [2*WGT_W-1:0] prod;
  logic [TOT_W-1:0] total_c, init_load;
  logic [WGT_W-1:0] w_c;
  logic [TOT_W:0]   sum_c;
  logic             last_wkr, opens, used;
  logic             div_done;
  logic [TOT_W-1:0] div_quo;
  logic [2*ROW_W-1:0] rd_data;

  always_comb begin
    n_sat = (in_row_limit > ROW_CAP) ? ROW_CAP : in_row_limit;
    if (in_worker_count == '0) begin
      t_sat = CNT_W'(1);
    end else if (in_worker_count > WKR_CAP) begin
      t_sat = WKR_CAP;
    end else begin
      t_sat = in_worker_count;
    end
    prod      = ({1'b0, n_r} + WGT_W'(1)) * ({1'b0, n_r} + WGT_W'(2));
    total_c   = prod[TOT_W:1];
    init_load = shape_r ? TOT_W'(1) : TOT_W'({1'b0, n_r} + WGT_W'(1));
    w_c       = shape_r ? (m_r + WGT_W'(1)) : ({1'b0, n_r} - m_r + WGT_W'(1));
    sum_c     = {1'b0, load_r} + (TOT_W + 1)'(w_c);
    last_wkr  = ({1'b0, cur_r} == (t_r - CNT_W'(1)));
    opens     = (sum_c > {1'b0, quota_r}) && !last_wkr;
    used      = (k_r <= cur_r);
  end

  assign sts.div_done = div_done;
  assign sts.at_end   = (m_r > {1'b0, n_r});
  assign sts.opens    = opens;
  assign sts.is_last  = ({1'b0, k_r} == (t_r - CNT_W'(1)));

  trwp_div #(
    .NUM_W (TOT_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  trwp_ram #(
    .WIDTH (2 * ROW_W),
    .DEPTH (MAX_WORKERS)
  ) u_ram (
    .clk   (clk),
    .we    ((cmd.step && opens) || cmd.flush),
    .waddr (cur_r[AW-1:0]),
    .wdata ({lo_r, hi_r}),
    .raddr (k_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      shape_r <= in_op;
      n_r     <= n_sat;
      t_r     <= t_sat;
    end
    if (cmd.init) begin
      total_r    <= total_c;
      num_r      <= total_c;
      den_r      <= t_r;
      load_r     <= init_load;
      done_sum_r <= init_load;
      m_r        <= WGT_W'(1);
      cur_r      <= '0;
      lo_r       <= '0;
      hi_r       <= '0;
    end
    if (div_done) begin
      quota_r <= (num_r > TOT_W'(t_r)) ? div_quo : TOT_W'(1);
    end
    if (cmd.step) begin
      if (opens) begin
        cur_r  <= cur_r + WKR_W'(1);
        lo_r   <= m_r[ROW_W-1:0];
        load_r <= TOT_W'(w_c);
        num_r  <= total_r - done_sum_r;
        den_r  <= t_r - CNT_W'({1'b0, cur_r} + CNT_W'(1));
      end else begin
        load_r <= sum_c[TOT_W-1:0];
      end
      hi_r       <= m_r[ROW_W-1:0];
      done_sum_r <= done_sum_r + TOT_W'(w_c);
      m_r        <= m_r + WGT_W'(1);
    end
    if (cmd.flush) begin
      k_r <= '0;
    end
    if (cmd.next) begin
      k_r <= k_r + WKR_W'(1);
    end
    if (cmd.ld) begin
      out_worker_index <= k_r;
      out_first_row    <= used ? rd_data[2*ROW_W-1:ROW_W] : ROW_W'(1);
      out_final_row    <= used ? rd_data[ROW_W-1:0] : '0;
      out_active       <= used;
      out_last         <= sts.is_last;
    end
  end

endmodule

// ===== rtl/core/trwp_ctrl.sv =====
module trwp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  trwp_pkg::trwp_sts_t sts,
  output trwp_pkg::trwp_cmd_t cmd
);

  import trwp_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DWAIT  = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_FLUSH  = 4'd5;
  localparam logic [3:0] S_RD     = 4'd6;
  localparam logic [3:0] S_LD     = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.at_end) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.step = 1'b1;
          if (sts.opens) begin
            state_nxt = S_DSTART;
          end
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.ld    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (sts.is_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

endmodule

// ===== rtl/core/triangular_row_work_partitioner.sv =====
// Splits the rows 0..N of a triangular double loop into contiguous ranges, one per
// worker, for a request of N (row limit), T (worker count) and the loop shape.
// in_*: one request item; in_tready is high only while no request is in work.
// out_*: exactly T result items per request in ascending worker order, tlast on
// the result of worker T-1; workers that get no rows report first 1, final 0,
// tuser (active) 0.
// Flow: the rows are walked one per cycle while no quota is being divided, and every
// opened worker recomputes its quota in the shared restoring divider (24 quotient
// bits, one per cycle). Each result then takes a range memory read, an output
// register load and the handshake. The next request is taken once the last result
// has been accepted.
// A stalled out_tready holds the result register and the whole block.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// request in work; the range memory needs no clearing.
module triangular_row_work_partitioner #(
  parameter int MAX_ROW     = trwp_pkg::DEF_MAX_ROW,
  parameter int MAX_WORKERS = trwp_pkg::DEF_MAX_WORKERS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [trwp_pkg::IN_TDATA_W-1:0]  in_tdata,   // row_limit, worker_count
  input  logic                             in_tuser,   // op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [trwp_pkg::OUT_TDATA_W-1:0] out_tdata,  // worker_index, first_row, final_row
  output logic                             out_tuser,  // active
  output logic                             out_tlast
);

  import trwp_pkg::*;

  trwp_cmd_t        cmd;
  trwp_sts_t        sts;
  logic [WKR_W-1:0] worker_index;
  logic [ROW_W-1:0] first_row, final_row;

  trwp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  trwp_dp #(
    .MAX_ROW     (MAX_ROW),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_tuser),
    .in_row_limit     (in_tdata[ROW_W-1:0]),
    .in_worker_count  (in_tdata[ROW_W+CNT_W-1:ROW_W]),
    .out_worker_index (worker_index),
    .out_first_row    (first_row),
    .out_final_row    (final_row),
    .out_active       (out_tuser),
    .out_last         (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - WKR_W - 2 * ROW_W)'(0), final_row, first_row,
                      worker_index};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request taken while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after final result");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result shown right after request accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast)))
    else $error("result changed while stalled");
`endif

endmodule
